>>> rtl/vilsa_pkg.sv
// ----------------------------------------------------------------------------
// vilsa_pkg
// Shared types and constants of the virtual interrupt list slot allocator.
// ----------------------------------------------------------------------------
package vilsa_pkg;

  localparam int SLOT_W     = 4;
  localparam int MASK_W     = 16;
  localparam int IRQ_W      = 10;
  localparam int FIRST_W    = 10;
  localparam int MAX_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int WORD_W     = 64;

  localparam logic [FIRST_W-1:0] FIRST_SPI_RESET = 10'd32;
  localparam logic [MAX_W-1:0]   MAX_IRQ_RESET   = 11'd1020;

  localparam logic [WORD_W-1:0] LR_STATE_PENDING = 64'd1 << 62;
  localparam logic [WORD_W-1:0] LR_GROUP1        = 64'd1 << 60;
  localparam logic [WORD_W-1:0] LR_PRIORITY      = 64'h80 << 48;
  localparam logic [WORD_W-1:0] LR_BIT41         = 64'd1 << 41;
  localparam logic [WORD_W-1:0] LR_WORD_BASE     =
    LR_STATE_PENDING | LR_GROUP1 | LR_PRIORITY | LR_BIT41;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_SPI = 2'd0,
    CFG_MAX_IRQ   = 2'd1
  } cfg_index_t;

  typedef enum logic {
    CMD_INJECT  = 1'b0,
    CMD_RELEASE = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    ST_WRITTEN  = 3'd0,
    ST_PRIVATE  = 3'd1,
    ST_DISABLED = 3'd2,
    ST_RANGE    = 3'd3,
    ST_FULL     = 3'd4,
    ST_NOTHING  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic eval;
  } dp_cmd_t;

  typedef struct packed {
    logic more;
  } dp_stat_t;

endpackage

>>> rtl/virtual_irq_list_slot_allocator.sv
// A request is registered when it is taken in S_IDLE, the slot search runs
// in S_EVAL and the result is registered and offered in S_EMIT. An inject or
// empty release gives one result; a release with k slot bits gives k results,
// one sequencer pass through the search per slot. Output stall holds S_EMIT;
// the next request is taken once the last result is gone. Reset (rst,
// synchronous) frees every slot and restores first_spi = 32, max_irq = 1020.
// ----------------------------------------------------------------------------
// virtual_irq_list_slot_allocator
// Lowest-free slot allocator for virtual interrupt list registers.
// ----------------------------------------------------------------------------
module virtual_irq_list_slot_allocator
  import vilsa_pkg::*;
#(
  parameter int NUM_LRS = 16
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  command,
  input  logic [IRQ_W-1:0]      irq_number,
  input  logic                  irq_en,
  input  logic [MASK_W-1:0]     eoi_mask,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic [SLOT_W-1:0]     slot_index,
  output logic [WORD_W-1:0]     slot_word,
  output logic                  last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  vilsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  vilsa_dp #(
    .NUM_LRS (NUM_LRS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .command     (command),
    .irq_number  (irq_number),
    .irq_en      (irq_en),
    .eoi_mask    (eoi_mask),
    .cmd         (cmd),
    .stat        (stat),
    .status      (status),
    .slot_index  (slot_index),
    .slot_word   (slot_word),
    .last        (last)
  );

endmodule

>>> rtl/vilsa_ctrl.sv
// ----------------------------------------------------------------------------
// vilsa_ctrl
// Sequencer: takes a request, steps the datapath once per result and holds
// each result until the consumer takes it.
// ----------------------------------------------------------------------------
module vilsa_ctrl
  import vilsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = stat.more ? S_EVAL : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/vilsa_dp.sv
// ----------------------------------------------------------------------------
// vilsa_dp
// Datapath: configuration registers, busy bitmap, request registers, lowest
// free / lowest pending slot search and the result register.
// ----------------------------------------------------------------------------
module vilsa_dp
  import vilsa_pkg::*;
#(
  parameter int NUM_LRS = 16
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  command,
  input  logic [IRQ_W-1:0]      irq_number,
  input  logic                  irq_en,
  input  logic [MASK_W-1:0]     eoi_mask,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic [2:0]            status,
  output logic [SLOT_W-1:0]     slot_index,
  output logic [WORD_W-1:0]     slot_word,
  output logic                  last
);

  logic [FIRST_W-1:0] first_spi;
  logic [MAX_W-1:0]   max_irq;
  logic [NUM_LRS-1:0] slot_busy;
  logic [NUM_LRS-1:0] pend;
  command_t           cmd_r;
  logic [IRQ_W-1:0]   nr_r;
  logic               en_r;

  status_t            status_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [WORD_W-1:0]  word_r;
  logic               last_r;

  logic [NUM_LRS-1:0] free_vec;
  logic [NUM_LRS-1:0] free_hot;
  logic [NUM_LRS-1:0] pend_hot;
  logic [SLOT_W-1:0]  free_idx;
  logic [SLOT_W-1:0]  pend_idx;

  function automatic logic [SLOT_W-1:0] enc(input logic [NUM_LRS-1:0] hot);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < NUM_LRS; i++) begin
      if (hot[i]) idx = idx | SLOT_W'(i);
    end
    return idx;
  endfunction

  assign free_vec = ~slot_busy;
  assign free_hot = free_vec & (~free_vec + NUM_LRS'(1));
  assign pend_hot = pend & (~pend + NUM_LRS'(1));
  assign free_idx = enc(free_hot);
  assign pend_idx = enc(pend_hot);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_spi <= FIRST_SPI_RESET;
      max_irq   <= MAX_IRQ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_SPI: first_spi <= cfg_data[FIRST_W-1:0];
        CFG_MAX_IRQ:   max_irq   <= cfg_data[MAX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy <= '0;
      pend      <= '0;
    end else if (cmd.load) begin
      pend <= (command == CMD_RELEASE) ? eoi_mask[NUM_LRS-1:0] : '0;
    end else if (cmd.eval) begin
      if (cmd_r == CMD_RELEASE) begin
        slot_busy <= slot_busy & ~pend_hot;
        pend      <= pend & ~pend_hot;
      end else if (nr_r >= first_spi && {1'b0, nr_r} < max_irq && en_r) begin
        slot_busy <= slot_busy | free_hot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= command_t'(command);
      nr_r  <= irq_number;
      en_r  <= irq_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      slot_r   <= '0;
      word_r   <= '0;
      last_r   <= 1'b1;
      if (cmd_r == CMD_RELEASE) begin
        if (pend == '0) begin
          status_r <= ST_NOTHING;
        end else begin
          status_r <= ST_WRITTEN;
          slot_r   <= pend_idx;
          last_r   <= ((pend & ~pend_hot) == '0);
        end
      end else begin
        priority if (nr_r < first_spi) begin
          status_r <= ST_PRIVATE;
        end else if ({1'b0, nr_r} >= max_irq) begin
          status_r <= ST_RANGE;
        end else if (!en_r) begin
          status_r <= ST_DISABLED;
        end else if (free_hot == '0) begin
          status_r <= ST_FULL;
        end else begin
          status_r <= ST_WRITTEN;
          slot_r   <= free_idx;
          word_r   <= LR_WORD_BASE | WORD_W'(nr_r);
        end
      end
    end
  end

  assign stat.more  = |pend;
  assign status     = status_r;
  assign slot_index = slot_r;
  assign slot_word  = word_r;
  assign last       = last_r;

endmodule

>>> rtl/vilsa_checker.sv
// ----------------------------------------------------------------------------
// vilsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module vilsa_checker
  import vilsa_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [2:0]            status,
  input logic [SLOT_W-1:0]     slot_index,
  input logic [WORD_W-1:0]     slot_word,
  input logic                  last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_index)
      && $stable(slot_word) && $stable(last))
    else $error("stalled result changed");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("request taken while a result is pending");

  a_fail_is_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_WRITTEN |-> last && slot_word == '0 && slot_index == '0)
    else $error("failure result malformed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_NOTHING)
    else $error("bad status code");

endmodule

bind virtual_irq_list_slot_allocator vilsa_checker u_vilsa_checker (.*);
